/* hw/rtl/gbn_pkg.sv */
// ============================================================================
// gbn_pkg
// Shared types and constants of the go-back-n sender: stream payload
// layouts, acknowledgement codes, configuration register indexes.
// ============================================================================
`default_nettype none

package gbn_pkg;

    localparam int BUFFER_DEPTH_DEF = 16;
    localparam int MAX_WINDOW_DEF   = 16;

    localparam int SEQ_W       = 32;
    localparam int WORD_W      = 64;
    localparam int TIMER_W     = 8;
    localparam int WIN_CFG_W   = 5;
    localparam int IN_FLIGHT_W = 5;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [WIN_CFG_W-1:0] WINDOW_RESET  = WIN_CFG_W'(1);
    localparam logic [TIMER_W-1:0]   TIMEOUT_RESET = TIMER_W'(10);

    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SIZE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_SLOTS = 1'b1;

    typedef enum logic [1:0] {
        ACK_OK      = 2'd0,
        ACK_HELLO   = 2'd1,
        ACK_WARNING = 2'd2,
        ACK_ERROR   = 2'd3
    } ack_kind_t;

    // members listed from the top bit down
    typedef struct packed {
        ack_kind_t ack_kind;
        logic      ack_valid;
        logic      offer_valid;
        logic      restart;
    } in_user_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  ack_seq;
        logic [WORD_W-1:0] offer_word;
        logic [SEQ_W-1:0]  offer_seq;
    } in_data_t;

    typedef struct packed {
        logic send_is_retx;
        logic send_valid;
    } out_user_t;

    typedef struct packed {
        logic [5:0]             pad;
        logic [IN_FLIGHT_W-1:0] in_flight;
        logic [SEQ_W-1:0]       base_seq;
        logic                   retransmission;
        logic                   timed_out;
        logic                   ack_accepted;
        logic                   seq_mismatch;
        logic                   window_full;
        logic [WORD_W-1:0]      send_word;
        logic [SEQ_W-1:0]       send_seq;
    } out_data_t;

    localparam int IN_USER_W  = $bits(in_user_t);
    localparam int IN_DATA_W  = $bits(in_data_t);
    localparam int OUT_USER_W = $bits(out_user_t);
    localparam int OUT_DATA_W = $bits(out_data_t);

endpackage

`default_nettype wire

/* hw/rtl/go_back_n_sender_slot.sv */
// ============================================================================
// go_back_n_sender_slot
// Go-back-n ARQ sender advanced by one time slot per input transaction.
// ============================================================================
// Usage:
//   s_* stream: one transaction per time slot, carrying an optional new
//   packet offer and an optional received acknowledgement.
//   m_* stream: exactly one result transaction per slot: the packet sent
//   (new or retransmitted), refusal flags, ack/timeout flags, base and
//   in-flight count after the slot.
//   cfg_* channel: register writes (index 0 window size, 1 timeout in
//   slots), ready whenever out of reset; write only while the block is idle.
// Result: registered, it appears in the cycle after the slot is accepted.
// Throughput: one slot per cycle when not stalled; the whole slot update is
// one pass of logic from the slot state registers into the result register.
// The packet store is a memory with a registered read: the retransmit read
// is issued with the slot and its data lands next to the result register.
// Reset: clears window, timer, retransmit state and valid marks and loads
// window 1, timeout 10; the packet store keeps its contents. Both input
// channels are not ready while reset is held.
// Stall: s_tready = !m_tvalid || m_tready, so a held result blocks the next
// slot only while m_tready is low.
// ============================================================================
`default_nettype none

module go_back_n_sender_slot #(
    parameter int BUFFER_DEPTH = gbn_pkg::BUFFER_DEPTH_DEF,
    parameter int MAX_WINDOW   = gbn_pkg::MAX_WINDOW_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // cfg
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [gbn_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire  [gbn_pkg::CFG_DATA_W-1:0]     cfg_data,
    // slot input
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  gbn_pkg::in_data_t            s_tdata,  // offer_seq, offer_word, ack_seq
    input  wire  gbn_pkg::in_user_t            s_tuser,  // restart, offer_valid, ack_valid,
                                                         // ack_kind
    // result output
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output gbn_pkg::out_data_t                 m_tdata,  // send_seq, send_word, window_full,
                                                         // seq_mismatch, ack_accepted,
                                                         // timed_out, retransmission,
                                                         // base_seq, in_flight, zero pad
    output gbn_pkg::out_user_t                 m_tuser   // send_valid, send_is_retx
);
    import gbn_pkg::*;

    localparam int SLOT_W  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int WIN_MAX = (MAX_WINDOW < BUFFER_DEPTH) ? MAX_WINDOW : BUFFER_DEPTH;
    localparam int CNT_W   = $clog2(WIN_MAX + 1);
    localparam int CMP_W   = (CNT_W > WIN_CFG_W) ? CNT_W : WIN_CFG_W;
    localparam int DIST_W  = ((SLOT_W + 1) > CMP_W) ? (SLOT_W + 1) : CMP_W;

    // next slot index of a sequence number, honoring the 32-bit wrap
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot,
                                                   input logic [SEQ_W-1:0]  ptr);
        logic [SLOT_W-1:0] res;
        if (ptr == {SEQ_W{1'b1}}) begin
            res = '0;
        end else if (slot == SLOT_W'(BUFFER_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = slot + SLOT_W'(1);
        end
        return res;
    endfunction

    // configuration
    logic [WIN_CFG_W-1:0] win_cfg_reg;
    logic [TIMER_W-1:0]   tmo_cfg_reg;

    // slot state
    logic [SEQ_W-1:0]        base_reg,      base_next;
    logic [SEQ_W-1:0]        next_reg,      next_next;
    logic [CNT_W-1:0]        out_reg,       out_next;
    logic [TIMER_W-1:0]      timer_reg,     timer_next;
    logic                    retx_mode_reg, retx_mode_next;
    logic [SEQ_W-1:0]        retx_reg,      retx_next;
    logic [SLOT_W-1:0]       base_slot_reg, base_slot_next;
    logic [SLOT_W-1:0]       next_slot_reg, next_slot_next;
    logic [SLOT_W-1:0]       retx_slot_reg, retx_slot_next;
    logic [BUFFER_DEPTH-1:0] valid_reg,     valid_next;

    // result
    logic      m_tvalid_reg;
    out_data_t res_reg,   res_next;
    out_user_t ruser_reg, ruser_next;
    logic      use_mem_reg, use_mem_next;

    // packet store
    logic [WORD_W-1:0] store_mem [BUFFER_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wslot;
    logic [SLOT_W-1:0] mem_rslot;

    logic              accept;
    logic [CMP_W-1:0]  eff_win;

    assign cfg_ready = aresetn;
    assign s_tready  = aresetn && (!m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        if (win_cfg_reg == '0) begin
            eff_win = CMP_W'(1);
        end else if (CMP_W'(win_cfg_reg) > CMP_W'(WIN_MAX)) begin
            eff_win = CMP_W'(WIN_MAX);
        end else begin
            eff_win = CMP_W'(win_cfg_reg);
        end
    end

    // one slot: restart, send, acknowledge, timer
    always_comb begin
        logic [SEQ_W-1:0]  d;
        logic [SEQ_W-1:0]  old_base;
        logic [SLOT_W-1:0] old_bslot;
        logic              wrap;
        logic [DIST_W-1:0] span;
        logic [DIST_W-1:0] off;
        logic [SLOT_W:0]   bsum;

        d         = '0;
        old_base  = '0;
        old_bslot = '0;
        wrap      = 1'b0;
        span      = '0;
        off       = '0;
        bsum      = '0;

        base_next      = base_reg;
        next_next      = next_reg;
        out_next       = out_reg;
        timer_next     = timer_reg;
        retx_mode_next = retx_mode_reg;
        retx_next      = retx_reg;
        base_slot_next = base_slot_reg;
        next_slot_next = next_slot_reg;
        retx_slot_next = retx_slot_reg;
        valid_next     = valid_reg;

        res_next     = '0;
        ruser_next   = '0;
        use_mem_next = 1'b0;
        mem_we       = 1'b0;
        mem_wslot    = next_slot_reg;
        mem_rslot    = retx_slot_reg;

        if (s_tuser.restart) begin
            base_next      = '0;
            next_next      = '0;
            out_next       = '0;
            timer_next     = '0;
            retx_mode_next = 1'b0;
            retx_next      = '0;
            base_slot_next = '0;
            next_slot_next = '0;
            retx_slot_next = '0;
            valid_next     = '0;
        end

        // send
        if (retx_mode_next) begin
            if ((retx_next - base_next) < SEQ_W'(out_next)) begin
                mem_rslot = retx_slot_next;
                if (valid_next[retx_slot_next]) begin
                    ruser_next.send_valid    = 1'b1;
                    ruser_next.send_is_retx  = 1'b1;
                    res_next.send_seq        = retx_next;
                    res_next.retransmission  = 1'b1;
                    use_mem_next             = 1'b1;
                end
                retx_slot_next = slot_inc(retx_slot_next, retx_next);
                retx_next      = retx_next + SEQ_W'(1);
            end else begin
                retx_mode_next = 1'b0;
            end
        end else if (s_tuser.offer_valid) begin
            if (CMP_W'(out_next) >= eff_win) begin
                res_next.window_full = 1'b1;
            end else if (s_tdata.offer_seq != next_next) begin
                res_next.seq_mismatch = 1'b1;
            end else begin
                mem_we                     = 1'b1;
                mem_wslot                  = next_slot_next;
                valid_next[next_slot_next] = 1'b1;
                ruser_next.send_valid      = 1'b1;
                res_next.send_seq          = next_next;
                res_next.send_word         = s_tdata.offer_word;
                next_slot_next             = slot_inc(next_slot_next, next_next);
                next_next                  = next_next + SEQ_W'(1);
                out_next                   = out_next + CNT_W'(1);
                if (out_next == CNT_W'(1)) begin
                    timer_next = tmo_cfg_reg;
                end
            end
        end

        // acknowledge
        if (s_tuser.ack_valid && (s_tuser.ack_kind == ACK_OK || s_tuser.ack_kind == ACK_HELLO)
                && out_next != '0) begin
            d = s_tdata.ack_seq - base_next;
            if (d != '0 && d <= SEQ_W'(out_next)) begin
                old_base  = base_next;
                old_bslot = base_slot_next;
                // sequence space wrapped inside the acked range
                wrap      = s_tdata.ack_seq < old_base;
                span      = wrap ? DIST_W'(SEQ_W'(0) - old_base) : DIST_W'(d);
                for (int j = 0; j < BUFFER_DEPTH; j++) begin
                    off = DIST_W'(j) - DIST_W'(old_bslot);
                    if (DIST_W'(j) < DIST_W'(old_bslot)) begin
                        off = off + DIST_W'(BUFFER_DEPTH);
                    end
                    if (off < span || (wrap && SEQ_W'(j) < s_tdata.ack_seq)) begin
                        valid_next[j] = 1'b0;
                    end
                end
                if (wrap) begin
                    base_slot_next = SLOT_W'(s_tdata.ack_seq);
                end else begin
                    bsum = (SLOT_W + 1)'(old_bslot) + (SLOT_W + 1)'(d);
                    if (bsum >= (SLOT_W + 1)'(BUFFER_DEPTH)) begin
                        bsum = bsum - (SLOT_W + 1)'(BUFFER_DEPTH);
                    end
                    base_slot_next = SLOT_W'(bsum);
                end
                base_next             = s_tdata.ack_seq;
                out_next              = out_next - CNT_W'(d);
                res_next.ack_accepted = 1'b1;
                if (out_next != '0) begin
                    timer_next = tmo_cfg_reg;
                end else begin
                    timer_next     = '0;
                    retx_mode_next = 1'b0;
                    retx_next      = '0;
                    retx_slot_next = '0;
                end
                if (retx_mode_next && (retx_next - old_base) < d) begin
                    retx_next      = base_next;
                    retx_slot_next = base_slot_next;
                end
            end
        end

        // timer of the oldest packet
        if (out_next != '0) begin
            if (timer_next <= TIMER_W'(1)) begin
                retx_mode_next          = 1'b1;
                retx_next               = base_next;
                retx_slot_next          = base_slot_next;
                timer_next              = tmo_cfg_reg;
                res_next.timed_out      = 1'b1;
                res_next.retransmission = 1'b1;
            end else begin
                timer_next = timer_next - TIMER_W'(1);
            end
        end

        res_next.base_seq  = base_next;
        res_next.in_flight = IN_FLIGHT_W'(out_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cfg_reg <= WINDOW_RESET;
            tmo_cfg_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_WINDOW_SIZE:   win_cfg_reg <= cfg_data[WIN_CFG_W-1:0];
                CFG_TIMEOUT_SLOTS: tmo_cfg_reg <= cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            next_reg      <= '0;
            out_reg       <= '0;
            timer_reg     <= '0;
            retx_mode_reg <= 1'b0;
            retx_reg      <= '0;
            base_slot_reg <= '0;
            next_slot_reg <= '0;
            retx_slot_reg <= '0;
            valid_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                base_reg      <= base_next;
                next_reg      <= next_next;
                out_reg       <= out_next;
                timer_reg     <= timer_next;
                retx_mode_reg <= retx_mode_next;
                retx_reg      <= retx_next;
                base_slot_reg <= base_slot_next;
                next_slot_reg <= next_slot_next;
                retx_slot_reg <= retx_slot_next;
                valid_reg     <= valid_next;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg     <= res_next;
            ruser_reg   <= ruser_next;
            use_mem_reg <= use_mem_next;
        end
    end

    // packet store: written for new packets, read for retransmissions
    always_ff @(posedge aclk) begin
        if (accept && mem_we) begin
            store_mem[mem_wslot] <= s_tdata.offer_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= store_mem[mem_rslot];
        end
    end

    always_comb begin
        m_tdata = res_reg;
        if (use_mem_reg) begin
            m_tdata.send_word = rd_data_reg;
        end
        m_tuser = ruser_reg;
    end

endmodule

`default_nettype wire

/* hw/rtl/gbn_checker.sv */
// ============================================================================
// gbn_checker
// Port-level checks of the go-back-n sender, bound to its top level.
// ============================================================================
`default_nettype none

module gbn_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [gbn_pkg::OUT_DATA_W-1:0]      m_tdata,
    input wire [gbn_pkg::OUT_USER_W-1:0]      m_tuser
);
    import gbn_pkg::*;

    out_data_t od;
    out_user_t ou;

    assign od = m_tdata;
    assign ou = m_tuser;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // every accepted slot yields a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("slot accepted without result");

    a_retx_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ou.send_is_retx |-> ou.send_valid && od.retransmission)
        else $error("retransmit mark without a send");

    // a refused offer never coincides with a transmission
    a_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ou.send_valid |-> !od.window_full && !od.seq_mismatch)
        else $error("send with refusal flag");

    a_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && od.timed_out |-> od.retransmission && od.in_flight != '0)
        else $error("timeout without retransmission or packets");

endmodule

bind go_back_n_sender_slot gbn_checker u_gbn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
